// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define PMRC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check that a condition implies a consequence in the next cycle
`define PMRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pmrc_pkg.sv =====
// Shared constants and controller/datapath types for the packet mask classifier.
package pmrc_pkg;

   localparam int NUM_RULES    = 8;
   localparam int MAX_MASK_LEN = 64;
   localparam int PACKET_BYTES = 2048;

   localparam int RULE_W  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
   localparam int CNT_W   = $clog2(NUM_RULES + 1);
   localparam int MASK_AW = $clog2(MAX_MASK_LEN);
   localparam int MIDX_W  = $clog2(MAX_MASK_LEN + 1);
   localparam int POS_W   = $clog2(PACKET_BYTES + 2);
   localparam int RAM_DEPTH = NUM_RULES * MAX_MASK_LEN;
   localparam int ADDR_W  = $clog2(RAM_DEPTH);

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_MASK   = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOROOM  = 2'd2;
   localparam logic [1:0] ST_TOOLONG = 2'd3;

   typedef struct packed {
      logic latch;
      logic ri_zero;
      logic ri_count;
      logic ri_inc;
      logic ri_dec;
      logic scan_dn;
      logic chk_rd;
      logic chk_ev;
      logic pos_adv;
      logic pkt_clr;
      logic cnt_clr;
      logic cnt_step;
      logic emit_load;
      logic drop_load;
      logic toolong_load;
      logic op_exec;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             last;
      logic             too_long;
      logic             ri_is_zero;
      logic             ri_at_count;
      logic             rule_ok;
      logic             rule_emit;
      logic             nemit_zero;
      logic             emit_final;
      logic             out_free;
      logic             table_empty;
      logic [CNT_W-1:0] rule_cnt;
   } sts_type;

endpackage

// ===== rtl/pmrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pmrc_ctrl.sv =====
// Controller state machine sequencing rule checks, counting and result emission.
module pmrc_ctrl import pmrc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_CHK_RD, S_CHK_EV, S_PKT_END, S_CNT, S_EMIT, S_OP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.kind == KIND_BYTE) begin
               cmd.ri_zero = 1'b1;
               state_in = (sts.too_long || sts.table_empty) ? S_PKT_END : S_CHK_RD;
            end else begin
               state_in = S_OP;
            end
         end
         S_CHK_RD: begin
            cmd.chk_rd = 1'b1;
            state_in   = S_CHK_EV;
         end
         S_CHK_EV: begin
            cmd.chk_ev = 1'b1;
            cmd.ri_inc = 1'b1;
            state_in   = S_CHK_RD;
            if (sts.ri_at_count) begin
               state_in = S_PKT_END;
            end
         end
         S_PKT_END: begin
            if (!sts.last) begin
               cmd.pos_adv = 1'b1;
               state_in    = S_IDLE;
            end else if (sts.too_long) begin
               if (sts.out_free) begin
                  cmd.toolong_load = 1'b1;
                  cmd.pkt_clr      = 1'b1;
                  state_in         = S_IDLE;
               end
            end else begin
               cmd.ri_count = 1'b1;
               cmd.cnt_clr  = 1'b1;
               state_in     = S_CNT;
            end
         end
         S_CNT: begin
            cmd.scan_dn = 1'b1;
            if (sts.ri_is_zero) begin
               cmd.ri_count = 1'b1;
               state_in     = S_EMIT;
            end else begin
               cmd.cnt_step = 1'b1;
               cmd.ri_dec   = 1'b1;
            end
         end
         S_EMIT: begin
            cmd.scan_dn = 1'b1;
            if (sts.nemit_zero) begin
               if (sts.out_free) begin
                  cmd.drop_load = 1'b1;
                  cmd.pkt_clr   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (sts.rule_emit) begin
               if (sts.out_free) begin
                  cmd.emit_load = 1'b1;
                  cmd.ri_dec    = 1'b1;
                  if (sts.emit_final) begin
                     cmd.pkt_clr = 1'b1;
                     state_in    = S_IDLE;
                  end
               end
            end else begin
               cmd.ri_dec = 1'b1;
            end
         end
         S_OP: begin
            if (sts.out_free) begin
               cmd.op_exec = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ===== rtl/pmrc_dp.sv =====
// Datapath: request latch, rule table, mask memory, packet state and result register.
module pmrc_dp import pmrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_tuser,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  cmd_type     cmd,
   output sts_type     sts
);

   logic [1:0]  kind_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [10:0] off_ff;
   logic [6:0]  len_ff;
   logic [15:0] port_ff;
   logic [7:0]  must_ff;
   logic [7:0]  may_ff;

   logic [10:0] off_tab_ff  [NUM_RULES];
   logic [6:0]  len_tab_ff  [NUM_RULES];
   logic [15:0] port_tab_ff [NUM_RULES];
   logic [6:0]  newest_len_ff;

   logic [CNT_W-1:0]  rule_cnt_ff;
   logic [MIDX_W-1:0] mask_idx_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [NUM_RULES-1:0] failed_ff;

   logic [CNT_W-1:0]  ri_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  nemit_ff;
   logic [CNT_W-1:0]  emitted_ff;
   logic              inwin_ff;
   logic [RULE_W-1:0] chk_idx_ff;

   logic        rsp_valid_ff;
   logic [15:0] out_port_ff;
   logic        has_dest_ff;
   logic [3:0]  match_cnt_ff;
   logic [1:0]  status_ff;
   logic        final_ff;

   logic [RULE_W-1:0] rd_idx;
   logic [10:0]       off_r;
   logic [6:0]        len_r;
   logic [15:0]       port_r;
   logic [POS_W-1:0]  diff;
   logic              in_win;
   logic              rule_ok;
   logic              rule_emit;
   logic              too_long;
   logic              out_free;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   logic [15:0]       rd_data;
   logic              byte_fail;
   logic [RULE_W-1:0] new_idx;
   logic [RULE_W-1:0] top_idx;
   logic [6:0]        clamp_len;
   logic [POS_W:0]    win_end;
   logic [POS_W:0]    plen;
   logic              table_full;
   logic              mask_room;

   assign rd_idx  = cmd.scan_dn ? RULE_W'(ri_ff - CNT_W'(1)) : RULE_W'(ri_ff);
   assign off_r   = off_tab_ff[rd_idx];
   assign len_r   = len_tab_ff[rd_idx];
   assign port_r  = port_tab_ff[rd_idx];
   assign diff    = pos_ff - POS_W'(off_r);
   assign in_win  = (pos_ff >= POS_W'(off_r)) && (diff < POS_W'(len_r));
   assign win_end = (POS_W+1)'(off_r) + (POS_W+1)'(len_r);
   assign plen    = (POS_W+1)'(pos_ff) + (POS_W+1)'(1);
   assign rule_ok   = (win_end <= plen) && !failed_ff[rd_idx];
   assign rule_emit = rule_ok && (port_r != 16'd0);
   assign too_long  = (pos_ff >= POS_W'(PACKET_BYTES));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign rd_addr = ADDR_W'(rd_idx) * ADDR_W'(MAX_MASK_LEN) + ADDR_W'(diff[MASK_AW-1:0]);
   assign new_idx = RULE_W'(rule_cnt_ff);
   assign top_idx = RULE_W'(rule_cnt_ff - CNT_W'(1));
   assign wr_addr = ADDR_W'(top_idx) * ADDR_W'(MAX_MASK_LEN) + ADDR_W'(mask_idx_ff);
   assign table_full = (rule_cnt_ff >= CNT_W'(NUM_RULES));
   assign mask_room  = (rule_cnt_ff != '0) && (MIDX_W'(newest_len_ff) > mask_idx_ff);
   assign wr_en   = cmd.op_exec && (kind_ff == KIND_MASK) && mask_room;
   assign clamp_len = (len_ff > 7'(MAX_MASK_LEN)) ? 7'(MAX_MASK_LEN) : len_ff;
   assign byte_fail = ((byte_ff & rd_data[15:8]) != rd_data[15:8]) ||
                      ((byte_ff & ~rd_data[7:0]) != 8'd0);

   pmrc_ram #(.WIDTH(16), .DEPTH(RAM_DEPTH)) u_mask_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({must_ff, may_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_tuser;
         byte_ff <= req_tdata[7:0];
         last_ff <= req_tlast;
         off_ff  <= req_tdata[18:8];
         len_ff  <= req_tdata[25:19];
         port_ff <= req_tdata[41:26];
         must_ff <= req_tdata[49:42];
         may_ff  <= req_tdata[57:50];
      end
      if (cmd.chk_rd) begin
         inwin_ff   <= in_win;
         chk_idx_ff <= rd_idx;
      end
      if (cmd.ri_zero) begin
         ri_ff <= '0;
      end else if (cmd.ri_count) begin
         ri_ff <= rule_cnt_ff;
      end else if (cmd.ri_inc) begin
         ri_ff <= ri_ff + CNT_W'(1);
      end else if (cmd.ri_dec) begin
         ri_ff <= ri_ff - CNT_W'(1);
      end
      if (cmd.cnt_clr) begin
         cnt_ff     <= '0;
         nemit_ff   <= '0;
      end else if (cmd.cnt_step) begin
         cnt_ff   <= cnt_ff + CNT_W'(rule_ok);
         nemit_ff <= nemit_ff + CNT_W'(rule_emit);
      end
      if (cmd.ri_count && !cmd.cnt_clr) begin
         emitted_ff <= '0;
      end else if (cmd.emit_load) begin
         emitted_ff <= emitted_ff + CNT_W'(1);
      end
      if (cmd.op_exec && (kind_ff == KIND_HEADER) && !table_full) begin
         off_tab_ff[new_idx]  <= off_ff;
         len_tab_ff[new_idx]  <= clamp_len;
         port_tab_ff[new_idx] <= port_ff;
         newest_len_ff        <= clamp_len;
      end
      if (cmd.emit_load) begin
         out_port_ff  <= port_r;
         has_dest_ff  <= 1'b1;
         match_cnt_ff <= 4'(cnt_ff);
         status_ff    <= ST_OK;
         final_ff     <= sts.emit_final;
      end else if (cmd.drop_load) begin
         out_port_ff  <= 16'd0;
         has_dest_ff  <= 1'b0;
         match_cnt_ff <= 4'(cnt_ff);
         status_ff    <= ST_OK;
         final_ff     <= 1'b1;
      end else if (cmd.toolong_load) begin
         out_port_ff  <= 16'd0;
         has_dest_ff  <= 1'b0;
         match_cnt_ff <= 4'd0;
         status_ff    <= ST_TOOLONG;
         final_ff     <= 1'b1;
      end else if (cmd.op_exec) begin
         out_port_ff  <= 16'd0;
         has_dest_ff  <= 1'b0;
         match_cnt_ff <= 4'd0;
         final_ff     <= 1'b1;
         case (kind_ff)
            KIND_HEADER: status_ff <= table_full ? ST_FULL : ST_OK;
            KIND_MASK:   status_ff <= mask_room ? ST_OK : ST_NOROOM;
            default:     status_ff <= ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_cnt_ff  <= '0;
         mask_idx_ff  <= '0;
         pos_ff       <= '0;
         failed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit_load || cmd.drop_load || cmd.toolong_load || cmd.op_exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.pkt_clr) begin
            pos_ff    <= '0;
            failed_ff <= '0;
         end else begin
            if (cmd.pos_adv) begin
               pos_ff <= too_long ? POS_W'(PACKET_BYTES + 1) : pos_ff + POS_W'(1);
            end
            if (cmd.chk_ev && inwin_ff && byte_fail) begin
               failed_ff[chk_idx_ff] <= 1'b1;
            end
            if (cmd.op_exec && (kind_ff == KIND_HEADER) && !table_full) begin
               failed_ff[new_idx] <= (pos_ff != '0);
            end
         end
         if (cmd.op_exec) begin
            case (kind_ff)
               KIND_HEADER: begin
                  if (!table_full) begin
                     rule_cnt_ff <= rule_cnt_ff + CNT_W'(1);
                     mask_idx_ff <= '0;
                  end
               end
               KIND_MASK: begin
                  if (mask_room) begin
                     mask_idx_ff <= mask_idx_ff + MIDX_W'(1);
                  end
               end
               KIND_CLEAR: begin
                  rule_cnt_ff <= '0;
                  mask_idx_ff <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      sts             = '0;
      sts.kind        = kind_ff;
      sts.last        = last_ff;
      sts.too_long    = too_long;
      sts.ri_is_zero  = (ri_ff == '0);
      sts.ri_at_count = ((ri_ff + CNT_W'(1)) == rule_cnt_ff);
      sts.rule_ok     = rule_ok;
      sts.rule_emit   = rule_emit;
      sts.nemit_zero  = (nemit_ff == '0);
      sts.emit_final  = ((emitted_ff + CNT_W'(1)) == nemit_ff);
      sts.out_free    = out_free;
      sts.table_empty = (rule_cnt_ff == '0);
      sts.rule_cnt    = rule_cnt_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, status_ff, match_cnt_ff, has_dest_ff, out_port_ff};
   assign rsp_tlast  = final_ff;

endmodule

// ===== rtl/packet_mask_rule_classifier_top.sv =====
// Top level of the mask/value packet rule classifier.
//
//   channel  | direction | contents
//   req_     | in        | tuser kind; tlast last; tdata byte, offset, length, port, masks
//   rsp_     | out       | tlast final_res; tdata port, has_dest, match_count, status
//
// For a packet byte the mask memory gives one read per stored rule, then a
// compare step. An empty table or a byte past the length limit skips the rule
// checks. A last byte then counts matches over every rule, then scans the rules
// down to the oldest emitting one (or gives a drop result when none emits).
// Rule, mask and clear requests skip the rule checks.
// Synchronous reset clears control state only; masks and rule entries are not
// cleared. A stalled result holds the sequencer until it is taken.
module packet_mask_rule_classifier_top import pmrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // data_byte, rule_offset, rule_length, dest_port,
                                   // must_one_byte, may_one_byte, zero pad
   input  logic [1:0]  req_tuser,  // kind
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_port, has_dest, match_count, status, zero pad
   output logic        rsp_tlast
);

`include "assert_macros.svh"

   cmd_type cmd;
   sts_type sts;

   pmrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pmrc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   `PMRC_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `PMRC_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, sts.rule_cnt <= CNT_W'(NUM_RULES), "rule count overflow")
   `PMRC_ASSERT_IMPL(a_load_free, clock, reset, cmd.emit_load || cmd.drop_load || cmd.toolong_load || cmd.op_exec, sts.out_free, "result overwritten")

endmodule
